>>> rtl/core/ale_pkg.sv
// ----------------------------------------------------------------------------
// ale_pkg
// Types, constants and fixed-point helpers for the affine Legendre expansion.
// ----------------------------------------------------------------------------
package ale_pkg;

  localparam int MaxDegree = 9;
  localparam int TriSize   = (MaxDegree + 1) * (MaxDegree + 2) / 2;
  localparam int AddrW     = $clog2(TriSize);

  typedef struct packed {
    logic signed [31:0] shift;
    logic signed [31:0] scale;
  } ale_in_t;

  typedef struct packed {
    logic [3:0]         row_degree;
    logic [3:0]         basis_order;
    logic signed [47:0] coefficient;
    logic               last;
  } ale_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_RD,
    ST_MUL,
    ST_SCALE,
    ST_ACC,
    ST_WR,
    ST_ERD,
    ST_EOUT
  } ale_state_t;

  // term kinds of one entry
  typedef enum logic [2:0] {
    T_SHIFT,
    T_UP,
    T_DOWN,
    T_BACK,
    T_DIAG,
    T_DONE
  } ale_term_t;

  // memory access request from sequencer
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [47:0]      wdata;
    logic [AddrW-1:0] raddr;
  } ale_mem_req_t;

  function automatic logic [31:0] ratio_a(input logic [3:0] n);
    case (n)
      4'd1: ratio_a = 32'd1073741824;
      4'd2: ratio_a = 32'd1610612736;
      4'd3: ratio_a = 32'd1789569707;
      4'd4: ratio_a = 32'd1879048192;
      4'd5: ratio_a = 32'd1932735283;
      4'd6: ratio_a = 32'd1968526677;
      4'd7: ratio_a = 32'd1994091959;
      4'd8: ratio_a = 32'd2013265920;
      4'd9: ratio_a = 32'd2028179001;
      default: ratio_a = 32'd0;
    endcase
  endfunction

  function automatic logic [31:0] ratio_b(input logic [3:0] n);
    case (n)
      4'd2: ratio_b = 32'd536870912;
      4'd3: ratio_b = 32'd715827883;
      4'd4: ratio_b = 32'd805306368;
      4'd5: ratio_b = 32'd858993459;
      4'd6: ratio_b = 32'd894784853;
      4'd7: ratio_b = 32'd920350135;
      4'd8: ratio_b = 32'd939524096;
      4'd9: ratio_b = 32'd954437177;
      default: ratio_b = 32'd0;
    endcase
  endfunction

  function automatic logic [31:0] ratio_c(input logic [3:0] l);
    case (l)
      4'd0: ratio_c = 32'd357913941;
      4'd1: ratio_c = 32'd429496730;
      4'd2: ratio_c = 32'd460175067;
      4'd3: ratio_c = 32'd477218588;
      4'd4: ratio_c = 32'd488064465;
      4'd5: ratio_c = 32'd495573150;
      4'd6: ratio_c = 32'd501079518;
      4'd7: ratio_c = 32'd505290270;
      4'd8: ratio_c = 32'd508614548;
      4'd9: ratio_c = 32'd511305630;
      default: ratio_c = 32'd0;
    endcase
  endfunction

  function automatic logic [31:0] ratio_d(input logic [3:0] l);
    case (l)
      4'd1: ratio_d = 32'd1073741824;
      4'd2: ratio_d = 32'd715827883;
      4'd3: ratio_d = 32'd644245094;
      4'd4: ratio_d = 32'd613566757;
      4'd5: ratio_d = 32'd596523236;
      4'd6: ratio_d = 32'd585677359;
      4'd7: ratio_d = 32'd578168674;
      4'd8: ratio_d = 32'd572662306;
      4'd9: ratio_d = 32'd568451554;
      default: ratio_d = 32'd0;
    endcase
  endfunction

  function automatic logic [AddrW-1:0] tri_addr(input logic [3:0] n, input logic [3:0] l);
    logic [7:0] t;
    t = ({4'd0, n} * {4'd0, n + 4'd1}) >> 1;
    tri_addr = AddrW'(t + {4'd0, l});
  endfunction

  // round |p| / 2^sh half away from zero, saturate to 48-bit signed
  function automatic logic signed [47:0] rnd_sat(input logic [79:0] mag, input logic neg,
                                                input logic [4:0] sh);
    logic [80:0] r;
    logic [80:0] lim;
    r   = ({1'b0, mag} + (81'd1 << (sh - 5'd1))) >> sh;
    lim = neg ? 81'h800000000000 : 81'h7FFFFFFFFFFF;
    if (r > lim) r = lim;
    rnd_sat = neg ? -$signed(r[47:0]) : $signed(r[47:0]);
  endfunction

endpackage

>>> rtl/core/ale_mul.sv
// ----------------------------------------------------------------------------
// ale_mul
// Shared registered multiplier: 48 x 32 magnitude product as two 24x32 halves.
// ----------------------------------------------------------------------------
module ale_mul
  import ale_pkg::*;
(
  input  logic               clk,
  input  logic               start,
  input  logic signed [47:0] a,
  input  logic signed [31:0] b,
  input  logic [4:0]         sh,
  output logic signed [47:0] p
);
  logic [47:0] ma;
  logic [31:0] mb;
  logic        neg;
  logic [55:0] plo;
  logic [55:0] phi;
  logic        neg_q;
  logic [4:0]  sh_q;

  assign ma = a[47] ? 48'(-a) : a;
  assign mb = b[31] ? 32'(-b) : b;
  assign neg = a[47] ^ b[31];

  always_ff @(posedge clk) begin
    if (start) begin
      plo   <= {8'd0, ma[23:0]} * {24'd0, mb};
      phi   <= {8'd0, ma[47:24]} * {24'd0, mb};
      neg_q <= neg;
      sh_q  <= sh;
    end
  end

  assign p = rnd_sat({24'd0, plo} + ({24'd0, phi} << 24), neg_q, sh_q);
endmodule

>>> rtl/core/ale_tri_mem.sv
// ----------------------------------------------------------------------------
// ale_tri_mem
// Coefficient triangle scratch store, one write and one registered read port.
// ----------------------------------------------------------------------------
module ale_tri_mem
  import ale_pkg::*;
(
  input  logic         clk,
  input  ale_mem_req_t req,
  output logic [47:0]  rdata
);
  logic [47:0] mem [TriSize];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end
endmodule

>>> rtl/core/affine_legendre_expansion.sv
// ----------------------------------------------------------------------------
// affine_legendre_expansion
// Legendre expansion of P_n(shift + scale*x) for n up to the set degree.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready take one transaction {shift, scale} (Q4.28). The block
//   then fills a scratch triangle in a single-port-read memory, one entry at
//   a time: each entry reads up to four earlier entries and runs the shift,
//   up and down terms through one shared 48x32 multiplier twice (argument,
//   then ratio) and the back and diagonal terms once. After that it reads the
//   triangle back in row order and presents one transaction per entry on
//   out_valid/out_ready with last on the final one. One item is handled at
//   a time, so in_ready is low until the last output is taken.
//   Reset (rst, synchronous) returns to idle and sets degree to 9; the
//   triangle is not cleared. A stalled receiver holds out_valid and the
//   payload. degree is to be written by cfg_we/cfg_data only while idle;
//   the block does not enforce it. Values above 9 act as 9.
// ----------------------------------------------------------------------------
module affine_legendre_expansion
  import ale_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [3:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  ale_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output ale_out_t   out_data
);
  ale_state_t state, state_next;
  ale_term_t  term;
  logic [3:0] degree, dmax;
  logic [3:0] n, l;
  logic [1:0] init_cnt;
  logic signed [31:0] s, k;
  logic signed [49:0] acc;
  logic signed [47:0] cur;
  logic signed [49:0] sum;
  logic signed [47:0] mul_a, mul_p;
  logic signed [31:0] mul_b, arg2, arg2_q;
  logic [4:0] mul_sh;
  logic mul_start;
  logic [47:0] rdata;
  ale_mem_req_t req;
  logic [3:0] rn, rl;
  logic term_used;
  logic [3:0] out_row, out_order;
  logic out_last;

  assign dmax = (degree > 4'(MaxDegree)) ? 4'(MaxDegree) : degree;

  always_ff @(posedge clk) begin
    if (rst) begin
      degree <= 4'd9;
    end else if (cfg_we) begin
      degree <= cfg_data;
    end
  end

  ale_tri_mem u_mem (.clk(clk), .req(req), .rdata(rdata));
  ale_mul u_mul (.clk(clk), .start(mul_start), .a(mul_a), .b(mul_b), .sh(mul_sh), .p(mul_p));

  // term applicability and source entry
  always_comb begin
    rn = n - 4'd1;
    rl = l;
    term_used = 1'b1;
    case (term)
      T_SHIFT: begin
        term_used = 1'b1;
      end
      T_UP: begin
        rl = l + 4'd1;
        term_used = (l + 4'd1) <= (n - 4'd1);
      end
      T_DOWN: begin
        rl = l - 4'd1;
        term_used = (l != 4'd0);
      end
      T_BACK: begin
        rn = n - 4'd2;
        term_used = (l + 4'd2) <= n;
      end
      T_DIAG: begin
        rl = l - 4'd1;
        term_used = (l == n);
      end
      default: term_used = 1'b0;
    endcase
  end

  always_comb begin
    case (term)
      T_UP:    arg2 = 32'(rnd_sat({48'd0, ratio_a(n)} * {48'd0, ratio_c(l)}, 1'b0, 5'd30));
      T_DOWN:  arg2 = 32'(rnd_sat({48'd0, ratio_a(n)} * {48'd0, ratio_d(l)}, 1'b0, 5'd30));
      default: arg2 = ratio_a(n);
    endcase
  end

  always_ff @(posedge clk) begin
    arg2_q <= arg2;
  end

  always_comb begin
    mul_start = 1'b0;
    mul_a = $signed(rdata);
    mul_b = s;
    mul_sh = 5'd28;
    case (state)
      ST_MUL: begin
        mul_start = 1'b1;
        case (term)
          T_SHIFT: mul_b = s;
          T_BACK: begin
            mul_b = $signed(ratio_b(n));
            mul_sh = 5'd30;
          end
          default: mul_b = k;
        endcase
      end
      ST_SCALE: begin
        mul_start = 1'b1;
        mul_a = mul_p;
        mul_b = arg2_q;
        mul_sh = 5'd30;
      end
      default: mul_start = 1'b0;
    endcase
  end

  assign sum = (term == T_BACK) ? 50'(acc) - 50'(mul_p) : 50'(acc) + 50'(mul_p);

  assign cur = (acc > 50'sh7FFFFFFFFFFF) ? 48'sh7FFFFFFFFFFF :
               (acc < -50'sh800000000000) ? -48'sh800000000000 : 48'(acc);

  always_comb begin
    req = '0;
    req.raddr = tri_addr(rn, rl);
    if (state == ST_INIT) begin
      req.we = 1'b1;
      case (init_cnt)
        2'd0: begin
          req.waddr = tri_addr(4'd0, 4'd0);
          req.wdata = 48'h0001_0000_0000;
        end
        2'd1: begin
          req.waddr = tri_addr(4'd1, 4'd0);
          req.wdata = {{12{s[31]}}, s, 4'd0};
        end
        default: begin
          req.waddr = tri_addr(4'd1, 4'd1);
          req.wdata = {{12{k[31]}}, k, 4'd0};
        end
      endcase
    end else if (state == ST_WR) begin
      req.we = 1'b1;
      req.waddr = tri_addr(n, l);
      req.wdata = cur;
    end else if (state == ST_ERD || state == ST_EOUT) begin
      req.raddr = tri_addr(n, l);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_INIT;
      ST_INIT:  if (init_cnt == 2'd2 || dmax == 4'd0) begin
        state_next = (dmax >= 4'd2) ? ST_RD : ST_ERD;
      end
      ST_RD:    state_next = (term == T_DONE) ? ST_WR : (term_used ? ST_MUL : ST_RD);
      ST_MUL:   state_next = (term == T_BACK || term == T_DIAG) ? ST_ACC : ST_SCALE;
      ST_SCALE: state_next = ST_ACC;
      ST_ACC:   state_next = ST_RD;
      ST_WR:    state_next = (l == n && n == dmax) ? ST_ERD : ST_RD;
      ST_ERD:   state_next = ST_EOUT;
      ST_EOUT:  if (out_ready) state_next = (n == dmax && l == n) ? ST_IDLE : ST_ERD;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        s <= in_data.shift;
        k <= in_data.scale;
        init_cnt <= 2'd0;
      end
      ST_INIT: begin
        init_cnt <= init_cnt + 2'd1;
        n <= (dmax >= 4'd2) ? 4'd2 : 4'd0;
        l <= 4'd0;
        term <= T_SHIFT;
        acc <= '0;
      end
      ST_RD: begin
        if (term != T_DONE && !term_used) begin
          term <= ale_term_t'(term + 3'd1);
        end
      end
      ST_ACC: begin
        acc <= (term == T_DIAG) ? 50'(mul_p) : sum;
        term <= (term == T_BACK || term == T_DIAG) ? T_DONE : ale_term_t'(term + 3'd1);
      end
      ST_WR: begin
        acc <= '0;
        if (l == n) begin
          if (n == dmax) begin
            n <= 4'd0;
          end else begin
            n <= n + 4'd1;
          end
          l <= 4'd0;
          term <= T_SHIFT;
        end else begin
          l <= l + 4'd1;
          term <= (l + 4'd1 == n) ? T_DIAG : T_SHIFT;
        end
      end
      ST_ERD: begin
        out_row <= n;
        out_order <= l;
        out_last <= (n == dmax) && (l == n);
      end
      ST_EOUT: begin
        if (out_ready) begin
          if (l == n) begin
            n <= n + 4'd1;
            l <= 4'd0;
          end else begin
            l <= l + 4'd1;
          end
        end
      end
      default: acc <= acc;
    endcase
  end

  assign out_data  = {out_row, out_order, rdata, out_last};
  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_EOUT);

`ifndef SYNTHESIS
  a_out_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.basis_order <= out_data.row_degree) else $error("bad index");
  a_last_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_data.last) |=> in_ready) else $error("no idle after last");
  a_no_both: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("overlap");
`endif
endmodule
